// ===== rtl/trial_division_factorizer_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the trial division factorizer.
// Both expect a clock clk_i and an active-low reset rst_ni in scope.
// ---------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_FACTORIZER_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tdf_pkg.sv =====
// ---------------------------------------------------------------------------
// tdf_pkg
// Shared constants and controller/datapath signal groups of the factorizer.
// ---------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

  localparam int unsigned VALUE_BITS = 31;

  // Source of an emitted factor.
  typedef enum logic [1:0] {
    EMIT_TWO = 2'd0,
    EMIT_DIV = 2'd1,
    EMIT_REM = 2'd2
  } emit_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      shift_two;
    logic      emit;
    emit_sel_e emit_sel;
    logic      take_quo;
    logic      bump_d;
    logic      div_start;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_lt2;
    logic n_even;
    logic n_gt2;
    logic div_last;
    logic rem_zero;
    logic d_gt_q;
    logic q_is1;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/tdf_in_if.sv =====
// ---------------------------------------------------------------------------
// tdf_in_if
// Input channel: one word carries the value to factor.
// ---------------------------------------------------------------------------
`default_nettype none

interface tdf_in_if #(
  parameter int unsigned VALUE_BITS = tdf_pkg::VALUE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdf_out_if.sv =====
// ---------------------------------------------------------------------------
// tdf_out_if
// Output channel: one word carries a prime factor and its last flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface tdf_out_if #(
  parameter int unsigned VALUE_BITS = tdf_pkg::VALUE_BITS
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] factor;
  logic                  last;

  modport source (output valid, output factor, output last, input ready);
  modport sink   (input valid, input factor, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tdf_divider.sv =====
// ---------------------------------------------------------------------------
// tdf_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tdf_divider #(
  parameter int unsigned VALUE_BITS = tdf_pkg::VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic [VALUE_BITS-1:0] quo_o,
  output logic                  rem_zero_o,
  output logic                  last_o
);

  localparam int unsigned CntBits = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [VALUE_BITS:0]   rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [VALUE_BITS-1:0] dvs_q, dvs_d;
  logic [VALUE_BITS:0]   rem_sh;
  logic                  fits;

  always_comb begin
    rem_sh = {rem_q[VALUE_BITS-1:0], quo_q[VALUE_BITS-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(VALUE_BITS);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quo_o      = quo_q;
  assign rem_zero_o = (rem_q == '0);
  assign last_o     = busy_q && (cnt_q == CntBits'(1));

endmodule

`default_nettype wire

// ===== rtl/tdf_datapath.sv =====
// ---------------------------------------------------------------------------
// tdf_datapath
// Remaining value, trial divisor, divider and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tdf_datapath #(
  parameter int unsigned VALUE_BITS = tdf_pkg::VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tdf_pkg::cmd_t         cmd_i,
  output tdf_pkg::status_t      status_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [VALUE_BITS-1:0] factor_o,
  output logic                  last_o
);

  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [VALUE_BITS-1:0] d_q, d_d;
  logic [VALUE_BITS-1:0] d_next;
  logic [VALUE_BITS-1:0] quo;
  logic                  rem_zero;
  logic                  div_last;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_divisor;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] factor_q, factor_d;
  logic                  last_q, last_d;
  logic                  out_free;

  assign d_next       = d_q + VALUE_BITS'(2);
  assign div_dividend = cmd_i.take_quo ? quo : n_q;
  assign div_divisor  = cmd_i.bump_d ? d_next : d_q;
  assign out_free     = !out_valid_q || out_ready_i;

  tdf_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quo_o      (quo),
    .rem_zero_o (rem_zero),
    .last_o     (div_last)
  );

  always_comb begin
    n_d = n_q;
    d_d = d_q;
    if (cmd_i.load) begin
      n_d = value_i;
      d_d = VALUE_BITS'(3);
    end else begin
      if (cmd_i.shift_two) begin
        n_d = n_q >> 1;
      end else if (cmd_i.take_quo) begin
        n_d = quo;
      end
      if (cmd_i.bump_d) begin
        d_d = d_next;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    factor_d    = factor_q;
    last_d      = last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      unique case (cmd_i.emit_sel)
        tdf_pkg::EMIT_TWO: begin
          factor_d = VALUE_BITS'(2);
          last_d   = (n_q == VALUE_BITS'(2));
        end
        tdf_pkg::EMIT_DIV: begin
          factor_d = d_q;
          last_d   = (quo == VALUE_BITS'(1));
        end
        tdf_pkg::EMIT_REM: begin
          factor_d = n_q;
          last_d   = 1'b1;
        end
        default: begin
          factor_d = n_q;
          last_d   = 1'b1;
        end
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    d_q      <= d_d;
    factor_q <= factor_d;
    last_q   <= last_d;
  end

  always_comb begin
    status_o.n_lt2    = (n_q < VALUE_BITS'(2));
    status_o.n_even   = !n_q[0];
    status_o.n_gt2    = (n_q > VALUE_BITS'(2));
    status_o.div_last = div_last;
    status_o.rem_zero = rem_zero;
    status_o.d_gt_q   = (d_q > quo);
    status_o.q_is1    = (quo == VALUE_BITS'(1));
    status_o.out_free = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== rtl/tdf_ctrl.sv =====
// ---------------------------------------------------------------------------
// tdf_ctrl
// Sequencer: strips factors of two, runs trial divisions, emits the rest.
// ---------------------------------------------------------------------------
`default_nettype none

module tdf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tdf_pkg::status_t status_i,
  output tdf_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV,
    ST_DECIDE,
    ST_FINAL
  } state_e;

  state_e state_q, state_d;
  // Set while the divisor still has to pass the square bound test.
  logic   check_q, check_d;

  always_comb begin
    state_d    = state_q;
    check_d    = check_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (status_i.n_lt2) begin
          state_d = ST_IDLE;
        end else if (status_i.n_even) begin
          if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_sel  = tdf_pkg::EMIT_TWO;
            cmd_o.shift_two = 1'b1;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          check_d         = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (check_q && status_i.d_gt_q) begin
          state_d = ST_FINAL;
        end else if (status_i.rem_zero) begin
          if (status_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = tdf_pkg::EMIT_DIV;
            cmd_o.take_quo = 1'b1;
            if (status_i.q_is1) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.div_start = 1'b1;
              check_d         = 1'b0;
              state_d         = ST_DIV;
            end
          end
        end else begin
          cmd_o.bump_d    = 1'b1;
          cmd_o.div_start = 1'b1;
          check_d         = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_FINAL: begin
        if (!status_i.n_gt2) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = tdf_pkg::EMIT_REM;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      check_q <= 1'b0;
    end else begin
      state_q <= state_d;
      check_q <= check_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/trial_division_factorizer.sv =====
// Operation: factors of two are stripped first; each odd trial divisor then runs
// through the shared one-bit-per-cycle divider, and that divider loop dominates
// the time per word. A new word is taken only once the sequencer is idle again.
// Reset: asynchronous, active low; it empties the output register and returns
// the sequencer to idle, with no clearing pass.
// ---------------------------------------------------------------------------
// trial_division_factorizer
// Prime factorization by trial division, factors out in ascending order.
// ---------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer #(
  parameter int unsigned VALUE_BITS = tdf_pkg::VALUE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdf_in_if.sink     in_i,
  tdf_out_if.source  out_o
);

  // The controller only sequences; every value lives in the datapath. They
  // talk through one command group and one status group.
  tdf_pkg::cmd_t    cmd;
  tdf_pkg::status_t status;

  // The sequencer takes a new word whenever it is idle. A finished factor may
  // still sit in the output register at that point, so a new value can start
  // while the previous list drains.
  tdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the remaining value, the current odd divisor, the
  // divider and the output register. Values below two produce no words;
  // the last flag is set when the remaining value reaches one, or on the
  // prime left over after the divisor passes its square root.
  tdf_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .value_i     (in_i.value),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .factor_o    (out_o.factor),
    .last_o      (out_o.last)
  );

endmodule

`default_nettype wire

// ===== rtl/tdf_checker.sv =====
// ---------------------------------------------------------------------------
// tdf_checker
// Port-level checks of the factorizer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "trial_division_factorizer_defines.svh"

module tdf_checker #(
  parameter int unsigned VALUE_BITS = tdf_pkg::VALUE_BITS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [VALUE_BITS-1:0] factor_i,
  input logic                  last_i
);

  logic                  in_list_q;
  logic [VALUE_BITS-1:0] prev_q;
  logic                  out_acc;

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_list_q <= 1'b0;
    end else if (out_acc) begin
      in_list_q <= !last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      prev_q <= factor_i;
    end
  end

  `TDF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(factor_i) && $stable(last_i), "output word changed while stalled")

  `TDF_ASSERT_NOW(a_factor_min, out_valid_i, factor_i >= VALUE_BITS'(2),
    "factor below two")

  `TDF_ASSERT_NOW(a_ascending, out_acc && in_list_q, factor_i >= prev_q,
    "factors not in ascending order")

  `TDF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i,
    "new value taken while the previous one is being factored")

endmodule

bind trial_division_factorizer tdf_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_tdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .factor_i    (out_o.factor),
  .last_i      (out_o.last)
);

`default_nettype wire
